@@ src/byte_ring_fifo_frame_drain_macros.svh @@
// Assertion macros shared by the byte ring FIFO checker.
// No dependencies.
`ifndef BYTE_RING_FIFO_FRAME_DRAIN_MACROS_SVH
`define BYTE_RING_FIFO_FRAME_DRAIN_MACROS_SVH

// concurrent assertion, masked while reset is high
`define BRFD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// concurrent assertion that also holds through reset
`define BRFD_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

@@ src/brfd_pkg.sv @@
// Shared types and constants for the byte ring FIFO with frame drain.
// No dependencies.
package brfd_pkg;

   localparam int DEPTH    = 64;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int DATA_W   = 8;
   localparam int AMOUNT_W = 6;
   localparam int CNT_W    = 6;
   localparam int STATUS_W = 2;

   localparam logic [AMOUNT_W-1:0] FRAME_LIMIT_RESET = 6'd63;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      MODE_PUT     = 3'd0,
      MODE_GET     = 3'd1,
      MODE_PEEK_AT = 3'd2,
      MODE_SKIP    = 3'd3,
      MODE_DISCARD = 3'd4,
      MODE_READ    = 3'd5,
      MODE_PEEK    = 3'd6,
      MODE_DRAIN   = 3'd7
   } mode_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;
      logic single;
      logic start_rd;
      logic step;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic stream;
      logic cnt_last;
   } dp_sts_type;

endpackage

@@ src/brfd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/brfd_ctrl.sv @@
// Control state machine of the byte ring FIFO: sequences decode and byte streaming.
// Depends on brfd_pkg.
module brfd_ctrl
   import brfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dp_sts_type  sts,
   output ctl_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_STREAM
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.latch = start;
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.stream) begin
               cmd.start_rd = 1'b1;
               state_in     = ST_STREAM;
            end else begin
               cmd.single = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_STREAM: begin
            cmd.step = 1'b1;
            if (sts.cnt_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

@@ src/brfd_dp.sv @@
// Datapath of the byte ring FIFO: pointers, byte store, counters and result registers.
// Depends on brfd_pkg and brfd_ram.
module brfd_dp
   import brfd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctl_cmd_type         cmd,
   output dp_sts_type          sts,
   input  logic [2:0]          req_mode,
   input  logic [DATA_W-1:0]   req_data_in,
   input  logic [AMOUNT_W-1:0] req_amount,
   input  logic                csr_write_enable,
   input  logic [AMOUNT_W-1:0] csr_write_data,
   output logic                rsp_strobe,
   output logic [DATA_W-1:0]   rsp_data_out,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ADDR_W-1:0]   rsp_level,
   output logic                rsp_last
);

   // latched request
   mode_type            mode_ff;
   logic [DATA_W-1:0]   data_ff;
   logic [AMOUNT_W-1:0] amount_ff;

   logic [ADDR_W-1:0]   wp_ff, wp_in;
   logic [ADDR_W-1:0]   rp_ff, rp_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ADDR_W-1:0]   lvl_ff, lvl_in;
   logic [AMOUNT_W-1:0] frame_limit_ff;
   logic [DEPTH-1:0]    valid_ff;
   logic                vld_q_ff;

   logic                strobe_ff, strobe_in;
   logic [DATA_W-1:0]   data_out_ff, data_out_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ADDR_W-1:0]   level_ff, level_in;
   logic                last_ff, last_in;

   logic [ADDR_W-1:0]   level;
   logic [ADDR_W-1:0]   wp_next;
   logic [ADDR_W-1:0]   rp_skip;
   logic [ADDR_W-1:0]   start_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [AMOUNT_W-1:0] limit;
   logic [CNT_W-1:0]    read_n;
   logic [CNT_W-1:0]    drain_n;
   logic [CNT_W-1:0]    n;
   logic                stream;
   logic                full;
   logic                ram_we;
   logic [DATA_W-1:0]   ram_q;

   assign level   = wp_ff - rp_ff;
   assign wp_next = wp_ff + 1'b1;
   assign full    = (wp_next == rp_ff);
   assign rp_skip = rp_ff + ADDR_W'(amount_ff);
   assign limit   = (frame_limit_ff == '0) ? AMOUNT_W'(1) : frame_limit_ff;
   assign read_n  = (CNT_W'(level) < CNT_W'(amount_ff)) ? CNT_W'(level) : CNT_W'(amount_ff);
   assign drain_n = (CNT_W'(level) < CNT_W'(limit)) ? CNT_W'(level) : CNT_W'(limit);
   assign start_addr = (mode_ff == MODE_PEEK_AT) ? rp_skip : rp_ff;

   // which commands read bytes, and how many
   always_comb begin
      stream = 1'b0;
      n      = CNT_W'(1);
      case (mode_ff)
         MODE_GET:     stream = (level != '0);
         MODE_PEEK_AT: stream = 1'b1;
         MODE_READ, MODE_PEEK: begin
            stream = (read_n != '0);
            n      = read_n;
         end
         MODE_DRAIN: begin
            stream = (level != '0);
            n      = drain_n;
         end
         default: stream = 1'b0;
      endcase
   end

   assign sts.stream   = stream;
   assign sts.cnt_last = (cnt_ff == CNT_W'(1));

   always_comb begin
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      addr_in     = addr_ff;
      cnt_in      = cnt_ff;
      lvl_in      = lvl_ff;
      rd_addr     = addr_ff;
      ram_we      = 1'b0;
      strobe_in   = 1'b0;
      data_out_in = data_out_ff;
      status_in   = status_ff;
      level_in    = level_ff;
      last_in     = last_ff;

      if (cmd.single) begin
         strobe_in   = 1'b1;
         data_out_in = '0;
         last_in     = 1'b1;
         status_in   = STATUS_OK;
         level_in    = level;
         case (mode_ff)
            MODE_PUT: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  ram_we   = 1'b1;
                  wp_in    = wp_next;
                  level_in = level + 1'b1;
               end
            end
            MODE_SKIP: begin
               rp_in    = rp_skip;
               level_in = wp_ff - rp_skip;
            end
            MODE_DISCARD: begin
               rp_in    = wp_ff;
               level_in = '0;
            end
            default: begin
               // get, read, peek or drain with nothing to give
               status_in = STATUS_EMPTY;
            end
         endcase
      end

      if (cmd.start_rd) begin
         rd_addr = start_addr;
         addr_in = start_addr + 1'b1;
         cnt_in  = n;
         lvl_in  = level;
         case (mode_ff)
            MODE_GET, MODE_READ: rp_in = rp_ff + ADDR_W'(n);
            MODE_DRAIN:          rp_in = wp_ff;
            default:             rp_in = rp_ff;
         endcase
      end

      if (cmd.step) begin
         strobe_in   = 1'b1;
         data_out_in = vld_q_ff ? ram_q : '0;
         status_in   = STATUS_OK;
         last_in     = (cnt_ff == CNT_W'(1));
         cnt_in      = cnt_ff - 1'b1;
         addr_in     = addr_ff + 1'b1;
         case (mode_ff)
            MODE_GET, MODE_READ: begin
               level_in = lvl_ff - 1'b1;
               lvl_in   = lvl_ff - 1'b1;
            end
            MODE_DRAIN: level_in = '0;
            default:    level_in = lvl_ff;
         endcase
      end
   end

   brfd_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (data_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff          <= '0;
         rp_ff          <= '0;
         valid_ff       <= '0;
         frame_limit_ff <= FRAME_LIMIT_RESET;
         strobe_ff      <= 1'b0;
      end else begin
         wp_ff     <= wp_in;
         rp_ff     <= rp_in;
         strobe_ff <= strobe_in;
         if (ram_we) begin
            valid_ff[wp_ff] <= 1'b1;
         end
         if (csr_write_enable) begin
            frame_limit_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff   <= mode_type'(req_mode);
         data_ff   <= req_data_in;
         amount_ff <= req_amount;
      end
      addr_ff     <= addr_in;
      cnt_ff      <= cnt_in;
      lvl_ff      <= lvl_in;
      vld_q_ff    <= valid_ff[rd_addr];   // tracks the RAM's registered read
      data_out_ff <= data_out_in;
      status_ff   <= status_in;
      level_ff    <= level_in;
      last_ff     <= last_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_data_out = data_out_ff;
   assign rsp_status   = status_ff;
   assign rsp_level    = level_ff;
   assign rsp_last     = last_ff;

endmodule

@@ src/byte_ring_fifo_frame_drain.sv @@
// Byte ring FIFO, 64 slots, at most 63 unread bytes. A request is taken when start is high and busy low.
// Put, skip, discard and every empty case: one result from decode; the next request can be taken
// while it is strobed. Get, peek_at, read, peek, drain: bytes come from the byte store's single
// registered read port, one byte per cycle; the next request can be taken while the last is strobed.
// Results are strobed for one cycle and cannot be stalled. Synchronous reset empties the ring,
// marks every slot as zero and sets frame_limit to 63.
module byte_ring_fifo_frame_drain
   import brfd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_mode,
   input  logic [DATA_W-1:0]   req_data_in,
   input  logic [AMOUNT_W-1:0] req_amount,
   input  logic                csr_write_enable,
   input  logic [AMOUNT_W-1:0] csr_write_data,
   output logic                rsp_strobe,
   output logic [DATA_W-1:0]   rsp_data_out,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ADDR_W-1:0]   rsp_level,
   output logic                rsp_last
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   brfd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   brfd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_mode         (req_mode),
      .req_data_in      (req_data_in),
      .req_amount       (req_amount),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_data_out     (rsp_data_out),
      .rsp_status       (rsp_status),
      .rsp_level        (rsp_level),
      .rsp_last         (rsp_last)
   );

endmodule

@@ src/brfd_checker.sv @@
// Port-level checks on the byte ring FIFO, bound to the top level.
// Depends on brfd_pkg and byte_ring_fifo_frame_drain_macros.svh.
`include "byte_ring_fifo_frame_drain_macros.svh"

module brfd_checker
   import brfd_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_strobe,
   input logic [DATA_W-1:0]   rsp_data_out,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_last
);

   // an accepted request keeps the block busy until its final result
   `BRFD_ASSERT(a_accept_busy, clock, reset, start && !busy |=> busy, "request accepted without busy")
   // a request's bytes come back to back
   `BRFD_ASSERT(a_burst_gapless, clock, reset, rsp_strobe && !rsp_last |=> rsp_strobe, "gap in byte burst")
   // the final result frees the block, earlier ones do not
   `BRFD_ASSERT(a_last_frees, clock, reset, rsp_strobe |-> (busy == !rsp_last), "busy disagrees with last")
   // refused or empty results carry no byte
   `BRFD_ASSERT(a_err_no_data, clock, reset, rsp_strobe && (rsp_status != STATUS_OK) |-> (rsp_data_out == '0) && rsp_last, "error result with data")
   // nothing comes out of reset
   `BRFD_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_strobe && !busy, "activity after reset")

endmodule

bind byte_ring_fifo_frame_drain brfd_checker u_brfd_checker (.*);

@@ sim/tb_top.sv @@
// Self-checking testbench for byte_ring_fifo_frame_drain: a directed table, then random phases.
// Results are checked against a ring predictor kept in step with each accepted request, or against a typed result.
// Depends on brfd_pkg and the byte_ring_fifo_frame_drain RTL.
`timescale 1ns / 100ps

module tb_top
   import brfd_pkg::*;
();

   localparam int CYCLE_LIMIT = 300000;

   typedef struct packed {
      logic [DATA_W-1:0]   data;
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   level;
      logic                last;
   } ring_result_type;

   // one row of the directed table; the result is typed in only where has_result is set
   typedef struct packed {
      mode_type            mode;
      logic [DATA_W-1:0]   data;
      logic [AMOUNT_W-1:0] amount;
      logic                has_result;
      logic [DATA_W-1:0]   x_data;
      logic [STATUS_W-1:0] x_status;
      logic [ADDR_W-1:0]   x_level;
   } cmd_row_type;

   localparam int N_ROWS = 24;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [2:0]          req_mode = MODE_PUT;
   logic [DATA_W-1:0]   req_data_in = '0;
   logic [AMOUNT_W-1:0] req_amount = '0;
   logic                csr_write_enable = 1'b0;
   logic [AMOUNT_W-1:0] csr_write_data = '0;
   logic                rsp_strobe;
   logic [DATA_W-1:0]   rsp_data_out;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0]   rsp_level;
   logic                rsp_last;

   // predictor state
   logic [DATA_W-1:0]   ring_mem [DEPTH];
   logic [ADDR_W-1:0]   wr_ptr;
   logic [ADDR_W-1:0]   rd_ptr;
   logic [AMOUNT_W-1:0] drain_limit;

   ring_result_type due_results [$];
   ring_result_type step_results [$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           no_idle_left = 0;

   cmd_row_type directed_rows [N_ROWS] = '{
      '{MODE_GET,     8'h00,  6'd0, 1'b1, 8'h00, STATUS_EMPTY, 6'd0},
      '{MODE_READ,    8'h00,  6'd5, 1'b1, 8'h00, STATUS_EMPTY, 6'd0},
      '{MODE_PEEK,    8'h00,  6'd5, 1'b1, 8'h00, STATUS_EMPTY, 6'd0},
      '{MODE_DRAIN,   8'h00,  6'd0, 1'b1, 8'h00, STATUS_EMPTY, 6'd0},
      '{MODE_PEEK_AT, 8'h00, 6'd63, 1'b1, 8'h00, STATUS_OK,    6'd0},
      '{MODE_PUT,     8'hFF,  6'd0, 1'b1, 8'h00, STATUS_OK,    6'd1},
      '{MODE_PUT,     8'h00, 6'd63, 1'b1, 8'h00, STATUS_OK,    6'd2},
      '{MODE_PUT,     8'hA5,  6'd0, 1'b1, 8'h00, STATUS_OK,    6'd3},
      '{MODE_READ,    8'h00,  6'd0, 1'b1, 8'h00, STATUS_EMPTY, 6'd3},
      '{MODE_PEEK,    8'h00, 6'd63, 1'b0, 8'h00, STATUS_OK,    6'd0},
      '{MODE_PEEK_AT, 8'h00,  6'd1, 1'b1, 8'h00, STATUS_OK,    6'd3},
      '{MODE_GET,     8'hFF,  6'd0, 1'b1, 8'hFF, STATUS_OK,    6'd2},
      '{MODE_READ,    8'h00,  6'd1, 1'b1, 8'h00, STATUS_OK,    6'd1},
      '{MODE_SKIP,    8'h00, 6'd63, 1'b0, 8'h00, STATUS_OK,    6'd0},
      '{MODE_READ,    8'h00, 6'd63, 1'b0, 8'h00, STATUS_OK,    6'd0},
      '{MODE_DISCARD, 8'h00,  6'd0, 1'b1, 8'h00, STATUS_OK,    6'd0},
      '{MODE_PUT,     8'h5A,  6'd0, 1'b1, 8'h00, STATUS_OK,    6'd1},
      '{MODE_PUT,     8'h3C,  6'd0, 1'b1, 8'h00, STATUS_OK,    6'd2},
      '{MODE_PUT,     8'h81,  6'd0, 1'b1, 8'h00, STATUS_OK,    6'd3},
      '{MODE_DRAIN,   8'h00,  6'd0, 1'b0, 8'h00, STATUS_OK,    6'd0},
      '{MODE_SKIP,    8'h00,  6'd0, 1'b1, 8'h00, STATUS_OK,    6'd0},
      '{MODE_PEEK_AT, 8'h00, 6'd63, 1'b0, 8'h00, STATUS_OK,    6'd0},
      '{MODE_PUT,     8'h7E,  6'd0, 1'b1, 8'h00, STATUS_OK,    6'd1},
      '{MODE_DISCARD, 8'hFF, 6'd63, 1'b1, 8'h00, STATUS_OK,    6'd0}
   };

   byte_ring_fifo_frame_drain DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_data_in      (req_data_in),
      .req_amount       (req_amount),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_data_out     (rsp_data_out),
      .rsp_status       (rsp_status),
      .rsp_level        (rsp_level),
      .rsp_last         (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [ADDR_W-1:0] ring_level();
      return wr_ptr - rd_ptr;
   endfunction

   // works out the results of one request and moves the ring state on
   task automatic ring_step(input mode_type m, input logic [DATA_W-1:0] d,
                            input logic [AMOUNT_W-1:0] amt);
      logic [ADDR_W-1:0]   lvl;
      logic [ADDR_W-1:0]   nxt;
      logic [ADDR_W-1:0]   idx;
      logic [ADDR_W-1:0]   first;
      logic [ADDR_W-1:0]   lvl_out;
      logic [AMOUNT_W-1:0] lim;
      logic [AMOUNT_W-1:0] n;
      lvl = ring_level();
      step_results.delete();
      case (m)
         MODE_PUT: begin
            nxt = wr_ptr + 6'd1;
            if (nxt == rd_ptr) begin
               step_results.push_back('{8'h00, STATUS_FULL, lvl, 1'b1});
            end else begin
               ring_mem[wr_ptr] = d;
               wr_ptr = nxt;
               step_results.push_back('{8'h00, STATUS_OK, ring_level(), 1'b1});
            end
         end
         MODE_GET: begin
            if (lvl == 0) begin
               step_results.push_back('{8'h00, STATUS_EMPTY, 6'd0, 1'b1});
            end else begin
               idx = rd_ptr;
               rd_ptr = rd_ptr + 6'd1;
               step_results.push_back('{ring_mem[idx], STATUS_OK, ring_level(), 1'b1});
            end
         end
         MODE_PEEK_AT: begin
            idx = rd_ptr + amt;
            step_results.push_back('{ring_mem[idx], STATUS_OK, lvl, 1'b1});
         end
         MODE_SKIP: begin
            // no bound check: the level may now count stale bytes
            rd_ptr = rd_ptr + amt;
            step_results.push_back('{8'h00, STATUS_OK, ring_level(), 1'b1});
         end
         MODE_DISCARD: begin
            rd_ptr = wr_ptr;
            step_results.push_back('{8'h00, STATUS_OK, 6'd0, 1'b1});
         end
         MODE_READ, MODE_PEEK: begin
            n = (lvl < amt) ? lvl : amt;
            if (n == 0) begin
               step_results.push_back('{8'h00, STATUS_EMPTY, lvl, 1'b1});
            end else begin
               for (int i = 0; i < n; i++) begin
                  idx = rd_ptr + i[ADDR_W-1:0];
                  lvl_out = (m == MODE_READ) ? lvl - i[ADDR_W-1:0] - 6'd1 : lvl;
                  step_results.push_back('{ring_mem[idx], STATUS_OK, lvl_out, (i == n - 1)});
               end
               if (m == MODE_READ)
                  rd_ptr = rd_ptr + n;
            end
         end
         default: begin
            if (lvl == 0) begin
               step_results.push_back('{8'h00, STATUS_EMPTY, 6'd0, 1'b1});
            end else begin
               // whole ring freed at once, bytes past the limit dropped
               first = rd_ptr;
               rd_ptr = wr_ptr;
               lim = (drain_limit == 0) ? 6'd1 : drain_limit;
               n = (lvl < lim) ? lvl : lim;
               for (int i = 0; i < n; i++) begin
                  idx = first + i[ADDR_W-1:0];
                  step_results.push_back('{ring_mem[idx], STATUS_OK, 6'd0, (i == n - 1)});
               end
            end
         end
      endcase
   endtask

   // presents one request, holds it until taken, then books its results
   task automatic send_request(input mode_type m, input logic [DATA_W-1:0] d,
                               input logic [AMOUNT_W-1:0] amt, input logic has_result,
                               input ring_result_type typed_result);
      int gap;
      if (no_idle_left > 0) begin
         gap = 0;
         no_idle_left--;
      end else begin
         if ($urandom_range(0, 9) == 0)
            no_idle_left = $urandom_range(5, 20);
         gap = $urandom_range(0, 18);
      end
      @(posedge clock);
      repeat (gap) @(posedge clock);
      start       <= 1'b1;
      req_mode    <= m;
      req_data_in <= d;
      req_amount  <= amt;
      do @(posedge clock); while (busy !== 1'b0);
      start <= 1'b0;
      ring_step(m, d, amt);
      if (has_result)
         due_results.push_back(typed_result);
      else
         foreach (step_results[i]) due_results.push_back(step_results[i]);
   endtask

   task automatic wait_until_settled();
      while (due_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_frame_limit(input logic [AMOUNT_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      drain_limit = value;
   endtask

   task automatic random_request();
      int                  r;
      int                  lvl;
      mode_type            m;
      logic [DATA_W-1:0]   d;
      logic [AMOUNT_W-1:0] amt;
      lvl = int'(ring_level());
      r   = $urandom_range(0, 99);
      d   = 8'($urandom_range(0, 255));
      amt = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                        : 6'($urandom_range(0, (lvl + 2 > 63) ? 63 : lvl + 2));
      if (r < 5) begin
         // noise: anything the fields allow
         m   = mode_type'($urandom_range(0, 7));
         amt = 6'($urandom_range(0, 63));
      end else if (r < ((lvl < 8) ? 60 : 35)) begin
         m = MODE_PUT;
      end else if (r < 48) begin
         m = MODE_GET;
      end else if (r < 55) begin
         m = MODE_PEEK_AT;
      end else if (r < 58) begin
         m = MODE_SKIP;
         if ($urandom_range(0, 3) != 0)
            amt = 6'($urandom_range(0, 3));
      end else if (r < 60) begin
         m = MODE_DISCARD;
      end else if (r < 75) begin
         m = MODE_READ;
      end else if (r < 85) begin
         m = MODE_PEEK;
      end else begin
         m = MODE_DRAIN;
      end
      send_request(m, d, amt, 1'b0, '0);
      if ($urandom_range(0, 24) == 0)
         wait_until_settled();
   endtask

   task automatic run_phase(input logic [AMOUNT_W-1:0] limit, input int count,
                            input bit fill_first);
      wait_until_settled();
      write_frame_limit(limit);
      if (fill_first) begin
         // fill to the brim, then push against the full ring
         while (ring_level() != DEPTH - 1)
            send_request(MODE_PUT, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                         1'b0, '0);
         repeat (2)
            send_request(MODE_PUT, 8'($urandom_range(0, 255)), 6'd0, 1'b0, '0);
         send_request(MODE_PEEK, 8'h00, 6'd63, 1'b0, '0);
         send_request(MODE_DRAIN, 8'h00, 6'd0, 1'b0, '0);
      end
      repeat (count) random_request();
   endtask

   always @(posedge clock) begin : check_results
      ring_result_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result data %h status %0d level %0d last %b",
                     $time, rsp_data_out, rsp_status, rsp_level, rsp_last);
            mismatch_count++;
         end else begin
            want = due_results.pop_front();
            if (rsp_data_out !== want.data) begin
               $display("%0t: data_out expected %h actual %h", $time, want.data, rsp_data_out);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_level !== want.level) begin
               $display("%0t: level expected %0d actual %0d", $time, want.level, rsp_level);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      ring_result_type typed;
      foreach (ring_mem[i]) ring_mem[i] = '0;
      wr_ptr      = '0;
      rd_ptr      = '0;
      drain_limit = FRAME_LIMIT_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part runs on the reset frame limit
      foreach (directed_rows[i]) begin
         typed = '{directed_rows[i].x_data, directed_rows[i].x_status,
                   directed_rows[i].x_level, 1'b1};
         send_request(directed_rows[i].mode, directed_rows[i].data, directed_rows[i].amount,
                      directed_rows[i].has_result, typed);
      end

      run_phase(6'd63, 40, 1'b1);
      run_phase(6'd0, 45, 1'b0);    // zero limit behaves as one
      run_phase(6'd1, 45, 1'b0);
      run_phase(6'd2, 45, 1'b0);
      run_phase(6'($urandom_range(1, 63)), 45, 1'b0);
      run_phase(6'($urandom_range(1, 63)), 45, 1'b0);

      while (due_results.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
